>>> design/cvfp_pkg.sv
// ----------------------------------------------------------------------------
// cvfp_pkg: shared types for the canonical varuint field parser
// item and result layouts, kind and error codes, parser phases
// ----------------------------------------------------------------------------
`default_nettype none

package cvfp_pkg;

	// register indexes of the configuration port
	localparam logic CFG_MAX_LENGTH    = 1'b0;
	localparam logic CFG_OPTIONAL_MODE = 1'b1;

	localparam logic [31:0] MAX_LENGTH_RESET = 32'd1024;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ABSENT  = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_OVERFLOW   = 3'd1,
		ERR_NONCANON   = 3'd2,
		ERR_LIMIT      = 3'd3,
		ERR_TRUNCATED  = 3'd4,
		ERR_PRESENCE   = 3'd5,
		ERR_RSVD6      = 3'd6,
		ERR_RSVD7      = 3'd7
	} err_code_t;

	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_ERROR   = 4'b1000
	} phase_t;

	// one buffer byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} item_t;

	// one parser result
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [31:0] field_length;
		logic       last_of_field;
		err_code_t  error_code;
	} result_t;

endpackage

`default_nettype wire

>>> design/cvfp_in_reg.sv
// ----------------------------------------------------------------------------
// cvfp_in_reg: input register
// holds one buffer byte until the parser step consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module cvfp_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  cvfp_pkg::item_t    in_item,
	input  wire logic          advance,
	output logic               item_valid,
	output cvfp_pkg::item_t    item
);
	import cvfp_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> design/cvfp_parse.sv
// ----------------------------------------------------------------------------
// cvfp_parse: field parser step
// parser state and the per-byte decision: presence, length octets, payload
// ----------------------------------------------------------------------------
`default_nettype none

module cvfp_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  cvfp_pkg::item_t    item,
	input  wire logic [31:0]   max_length,
	input  wire logic          optional_mode,
	output logic               res_valid,
	output cvfp_pkg::result_t  res
);
	import cvfp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] accum_q, accum_n;
	logic [2:0]  count_q, count_n;
	logic [31:0] left_q, left_n;
	err_code_t   err_q, err_n;

	// length octet datapath
	logic [2:0]  oct_n;
	logic [31:0] oct_base;
	logic [4:0]  shamt;
	logic [31:0] accum_new;
	logic [2:0]  count_new;
	logic        oct_overflow;
	logic        oct_noncanon;
	logic        oct_limit;
	logic [7:0]  b;
	logic        eob;

	assign b   = item.data_byte;
	assign eob = item.end_of_buffer;

	// a field start restarts the length from zero
	assign oct_n    = (phase_q == PH_START) ? 3'd0 : count_q;
	assign oct_base = (phase_q == PH_START) ? 32'd0 : accum_q;

	always_comb begin
		case (oct_n)
			3'd0:    shamt = 5'd0;
			3'd1:    shamt = 5'd7;
			3'd2:    shamt = 5'd14;
			3'd3:    shamt = 5'd21;
			default: shamt = 5'd28;
		endcase
	end

	assign accum_new    = oct_base | ({25'd0, b[6:0]} << shamt);
	assign count_new    = oct_n + 3'd1;
	// fifth octet may only carry four value bits, continuation included
	assign oct_overflow = oct_n[2] && (b[7:4] != 4'd0);
	// a longer form than needed ends on an all-zero octet
	assign oct_noncanon = (count_new != 3'd1) && (b[6:0] == 7'd0);
	assign oct_limit    = accum_new > max_length;

	always_comb begin
		phase_n   = phase_q;
		accum_n   = accum_q;
		count_n   = count_q;
		left_n    = left_q;
		err_n     = err_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, field_length: 32'd0,
			last_of_field: 1'b0, error_code: ERR_NONE};

		case (phase_q)
			PH_ERROR: begin
				res_valid      = 1'b1;
				res.kind       = KIND_ERROR;
				res.error_code = err_q;
			end
			PH_PAYLOAD: begin
				res.payload_byte = b;
				res.field_length = accum_q;
				if (left_q <= 32'd1) begin
					res_valid         = 1'b1;
					res.last_of_field = 1'b1;
					phase_n           = PH_START;
					left_n            = 32'd0;
				end else if (eob) begin
					res_valid        = 1'b1;
					res              = '{kind: KIND_ERROR, payload_byte: 8'd0,
						field_length: 32'd0, last_of_field: 1'b0, error_code: ERR_TRUNCATED};
					err_n            = ERR_TRUNCATED;
					phase_n          = PH_ERROR;
				end else begin
					res_valid = 1'b1;
					left_n    = left_q - 32'd1;
				end
			end
			default: begin
				if (phase_q == PH_START && optional_mode) begin
					// presence byte
					accum_n = 32'd0;
					count_n = 3'd0;
					if (b > 8'd1) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_PRESENCE;
						err_n          = ERR_PRESENCE;
						phase_n        = PH_ERROR;
					end else if (b == 8'd0) begin
						res_valid         = 1'b1;
						res.kind          = KIND_ABSENT;
						res.last_of_field = 1'b1;
						phase_n           = PH_START;
					end else if (eob) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_TRUNCATED;
						err_n          = ERR_TRUNCATED;
						phase_n        = PH_ERROR;
					end else begin
						phase_n = PH_LENGTH;
					end
				end else begin
					// length octet
					accum_n = accum_new;
					count_n = count_new;
					phase_n = PH_LENGTH;
					if (oct_overflow) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_OVERFLOW;
						err_n          = ERR_OVERFLOW;
						phase_n        = PH_ERROR;
					end else if (b[7]) begin
						if (eob) begin
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_TRUNCATED;
							err_n          = ERR_TRUNCATED;
							phase_n        = PH_ERROR;
						end
					end else if (oct_noncanon) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NONCANON;
						err_n          = ERR_NONCANON;
						phase_n        = PH_ERROR;
					end else if (oct_limit) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_LIMIT;
						err_n          = ERR_LIMIT;
						phase_n        = PH_ERROR;
					end else if (accum_new == 32'd0) begin
						res_valid         = 1'b1;
						res.kind          = KIND_EMPTY;
						res.last_of_field = 1'b1;
						phase_n           = PH_START;
					end else if (eob) begin
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_TRUNCATED;
						err_n          = ERR_TRUNCATED;
						phase_n        = PH_ERROR;
					end else begin
						left_n  = accum_new;
						phase_n = PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			accum_q <= 32'd0;
			count_q <= 3'd0;
			left_q  <= 32'd0;
			err_q   <= ERR_NONE;
		end else if (step) begin
			phase_q <= phase_n;
			accum_q <= accum_n;
			count_q <= count_n;
			left_q  <= left_n;
			err_q   <= err_n;
		end
	end

endmodule

`default_nettype wire

>>> design/cvfp_out_reg.sv
// ----------------------------------------------------------------------------
// cvfp_out_reg: result register
// holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module cvfp_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  cvfp_pkg::result_t  res,
	output logic               out_valid,
	input  wire logic          out_ready,
	output cvfp_pkg::result_t  out_res
);
	import cvfp_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

>>> design/canonical_varuint_field_parser.sv
// ----------------------------------------------------------------------------
// canonical_varuint_field_parser: length-prefixed field parser
// parses back-to-back fields (optional presence byte, canonical LEB128 uint32
// length, payload) from a byte stream, one byte per transfer
// ----------------------------------------------------------------------------
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tdata: data_byte; tlast: end_of_buffer
//  m_*      | out       | tdata: payload_byte, field_length, error_code;
//           |           | tlast: last_of_field; tuser: kind
//  cfg_*    | in        | write only: 0 max_length, 1 optional_mode
//
//  one byte per cycle sustained unless the result register stalls; a byte
//  waits in the input register for the parser step, and its result, if any,
//  appears in the result register the cycle after the parser step
//  all parser state advances in a single step per byte, so the next byte
//  follows immediately
//  reset clears the phase to field start, the sticky error and both valids;
//  max_length returns to 1024 and optional_mode to 0
//  a stalled result register holds the parser step, even for a byte with no
//  result; with a byte waiting, s_tready is !m_tvalid || m_tready in the same
//  cycle, and an empty input register still takes one byte
//
`default_nettype none

module canonical_varuint_field_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_buffer
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] payload_byte, [39:8] field_length,
	                                    // [42:40] error_code, [47:43] zero
	output logic             m_tlast,   // last_of_field
	output logic [1:0]       m_tuser,   // [1:0] kind
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import cvfp_pkg::*;

	// configuration registers
	logic [31:0] max_length_q;
	logic        optional_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q    <= MAX_LENGTH_RESET;
			optional_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LENGTH:    max_length_q    <= cfg_wdata;
				CFG_OPTIONAL_MODE: optional_mode_q <= cfg_wdata[0];
				default:           ;
			endcase
		end
	end

	item_t   in_item;
	item_t   item;
	logic    item_valid;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_item = '{data_byte: s_tdata, end_of_buffer: s_tlast};

	// the parser steps whenever a byte is held and the result register has room
	assign advance = item_valid && (!m_tvalid || m_tready);

	cvfp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	cvfp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item),
		.max_length    (max_length_q),
		.optional_mode (optional_mode_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	cvfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// result packing, lowest field first
	assign m_tdata = {5'd0, out_res.error_code, out_res.field_length, out_res.payload_byte};
	assign m_tlast = out_res.last_of_field;
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

>>> bench/tb_canonical_varuint_field_parser.sv
// ----------------------------------------------------------------------------
// tb_canonical_varuint_field_parser: self-checking bench for the field parser
// drives byte transfers with random gaps and result stalls, predicts every
// parser result in-bench and compares it field by field; directed fields
// first, then random well-formed fields under changing register settings,
// then one broken sequence that latches a sticky error
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_canonical_varuint_field_parser;

	import cvfp_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 6;   // input reg + result reg + margin
	localparam int unsigned TARGET_BYTES  = 650;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_wdata = 32'h0;

	// bench copy of the registers, mirrored on every write
	logic [31:0] cfg_max_len  = MAX_LENGTH_RESET;
	logic        cfg_optional = 1'b0;

	// bench copy of the parser state
	phase_t      parse_phase = PH_START;
	logic [31:0] len_acc     = 32'h0;
	int unsigned len_octets  = 0;
	logic [31:0] bytes_left  = 32'h0;
	err_code_t   sticky_err  = ERR_NONE;

	result_t     parsed_results[$];   // results still owed by the parser, oldest first
	int unsigned mismatches  = 0;
	int unsigned bytes_sent  = 0;
	int unsigned quiet_left  = 0;     // transfers left in a stretch with no input gaps

	canonical_varuint_field_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// parser prediction
	// ------------------------------------------------------------------------

	// latch an error code and build the error result that reports it
	function automatic result_t fail_with(err_code_t code);
		result_t res;
		res = '0;
		sticky_err = code;
		parse_phase = PH_ERROR;
		res.kind = KIND_ERROR;
		res.error_code = code;
		return res;
	endfunction

	// one LEB128 length octet; overflow first, then canonical form, limit,
	// and truncation once the length is complete
	task automatic take_length_octet(input logic [7:0] data, input logic eob,
			output bit produced, output result_t res);
		int unsigned need;
		produced = 1'b1;
		res = '0;
		// fifth octet may only carry bits 31:28, which also rules out a sixth
		if (len_octets >= 4 && data[7:4] != 4'h0) begin
			res = fail_with(ERR_OVERFLOW);
			return;
		end
		len_acc = len_acc | (32'(data[6:0]) << (7 * len_octets));
		len_octets = len_octets + 1;
		if (data[7]) begin
			if (eob)
				res = fail_with(ERR_TRUNCATED);
			else
				produced = 1'b0;
			return;
		end
		need = (len_acc < 32'h80)        ? 1 :
		       (len_acc < 32'h4000)      ? 2 :
		       (len_acc < 32'h20_0000)   ? 3 :
		       (len_acc < 32'h1000_0000) ? 4 : 5;
		if (len_octets != need) begin
			res = fail_with(ERR_NONCANON);
		end else if (len_acc > cfg_max_len) begin
			res = fail_with(ERR_LIMIT);
		end else if (len_acc == 32'h0) begin
			// empty field: one marker, next byte starts a new field
			parse_phase = PH_START;
			res.kind = KIND_EMPTY;
			res.last_of_field = 1'b1;
		end else if (eob) begin
			res = fail_with(ERR_TRUNCATED);
		end else begin
			bytes_left = len_acc;
			parse_phase = PH_PAYLOAD;
			produced = 1'b0;
		end
	endtask

	// advance the bench parser by one accepted byte and queue its result
	task automatic parse_byte(input logic [7:0] data, input logic eob);
		result_t res;
		bit      produced;
		produced = 1'b1;
		res = '0;
		if (parse_phase == PH_ERROR || sticky_err != ERR_NONE) begin
			// sticky: every byte answers with the latched code
			parse_phase = PH_ERROR;
			res.kind = KIND_ERROR;
			res.error_code = sticky_err;
		end else if (parse_phase == PH_START && cfg_optional) begin
			// presence byte, mode is sampled here at the field start
			len_acc = 32'h0;
			len_octets = 0;
			parse_phase = PH_LENGTH;
			if (data > 8'd1) begin
				res = fail_with(ERR_PRESENCE);
			end else if (data == 8'd0) begin
				parse_phase = PH_START;
				res.kind = KIND_ABSENT;
				res.last_of_field = 1'b1;
			end else if (eob) begin
				res = fail_with(ERR_TRUNCATED);
			end else begin
				produced = 1'b0;
			end
		end else if (parse_phase != PH_PAYLOAD) begin
			if (parse_phase == PH_START) begin
				len_acc = 32'h0;
				len_octets = 0;
				parse_phase = PH_LENGTH;
			end
			take_length_octet(data, eob, produced, res);
		end else if (bytes_left <= 32'd1) begin
			// final payload byte closes the field, end of buffer is fine here
			parse_phase = PH_START;
			bytes_left = 32'h0;
			res.kind = KIND_PAYLOAD;
			res.payload_byte = data;
			res.field_length = len_acc;
			res.last_of_field = 1'b1;
		end else if (eob) begin
			// buffer ends inside the payload, the error replaces this byte
			res = fail_with(ERR_TRUNCATED);
		end else begin
			bytes_left = bytes_left - 32'd1;
			res.kind = KIND_PAYLOAD;
			res.payload_byte = data;
			res.field_length = len_acc;
		end
		if (produced)
			parsed_results = {parsed_results, res};
	endtask

	// ------------------------------------------------------------------------
	// stimulus primitives, all entered and left just after a rising edge
	// ------------------------------------------------------------------------

	// one byte transfer with a random gap in front; valid stays high when the
	// next byte follows without a gap
	task automatic send_byte(input logic [7:0] data, input logic eob);
		int unsigned gap;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (quiet_left != 0) begin
			quiet_left--;
			gap = 0;
		end else if (roll < 3) begin
			quiet_left = $urandom_range(20, 60);
			gap = 0;
		end else if (roll < 50) begin
			gap = 0;
		end else if (roll < 85) begin
			gap = $urandom_range(1, 3);
		end else if (roll < 96) begin
			gap = $urandom_range(4, 10);
		end else begin
			gap = $urandom_range(20, 50);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_byte(data, eob);
		bytes_sent++;
	endtask

	// minimal LEB128 encoding; eob_last marks the final length octet
	task automatic send_length(input logic [31:0] value, input logic eob_last);
		logic [31:0] rest;
		logic [7:0]  octet;
		rest = value;
		do begin
			octet = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != 32'h0)
				octet[7] = 1'b1;
			send_byte(octet, (rest == 32'h0) ? eob_last : 1'b0);
		end while (rest != 32'h0);
	endtask

	// well-formed field under the current mode; eob rides on its last byte
	task automatic send_field(input bit absent, input logic [31:0] len, input logic eob);
		if (cfg_optional) begin
			if (absent) begin
				send_byte(8'h00, eob);
				return;
			end
			send_byte(8'h01, 1'b0);
		end
		send_length(len, (len == 32'h0) ? eob : 1'b0);
		for (int unsigned k = 0; k < len; k++)
			send_byte(8'($urandom), (k == len - 1) ? eob : 1'b0);
	endtask

	// stop the input and let every owed result and in-flight byte clear
	task automatic drain_parser();
		s_tvalid <= 1'b0;
		while (parsed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only while the parser is drained
	task automatic write_reg(input logic idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_LENGTH)
			cfg_max_len = value;
		else
			cfg_optional = value[0];
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset settings: plain fields, empty fields, payload extremes, end of
	// buffer at a field boundary
	task automatic check_plain_fields();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// presence bytes, and a mode change between the presence byte and the
	// length that must only take effect at the next field start
	task automatic check_optional_fields();
		drain_parser();
		write_reg(CFG_OPTIONAL_MODE, 32'd1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'ha5, 1'b1);
		send_byte(8'h01, 1'b0);
		drain_parser();
		write_reg(CFG_OPTIONAL_MODE, 32'd0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// limit extremes and a length exactly at the limit
	task automatic check_length_limits();
		drain_parser();
		write_reg(CFG_MAX_LENGTH, 32'd0);
		send_byte(8'h00, 1'b0);
		drain_parser();
		write_reg(CFG_MAX_LENGTH, 32'd2);
		send_byte(8'h02, 1'b0);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b1);
		drain_parser();
		write_reg(CFG_MAX_LENGTH, 32'hffff_ffff);
		send_byte(8'h01, 1'b0);
		send_byte(8'h5a, 1'b1);
	endtask

	// random well-formed fields in phases, registers changed between phases
	task automatic check_random_fields();
		int unsigned phase_end;
		int unsigned roll;
		logic [31:0] len;
		bit          absent;
		logic        eob;
		while (bytes_sent < TARGET_BYTES) begin
			drain_parser();
			roll = $urandom_range(0, 3);
			if (roll == 0 || roll == 1)
				write_reg(CFG_OPTIONAL_MODE, 32'($urandom_range(0, 1)));
			if (roll == 0 || roll == 2) begin
				case ($urandom_range(0, 9))
					0:       len = 32'd0;
					1:       len = 32'hffff_ffff;
					2, 3:    len = $urandom_range(1, 15);
					4, 5:    len = 32'd1024;
					6:       len = 32'd300;
					default: len = $urandom;
				endcase
				write_reg(CFG_MAX_LENGTH, len);
			end
			phase_end = bytes_sent + $urandom_range(60, 140);
			while (bytes_sent < phase_end) begin
				absent = cfg_optional && ($urandom_range(0, 3) == 0);
				roll = $urandom_range(0, 99);
				if (roll < 20)
					len = 32'd0;
				else if (roll < 80)
					len = $urandom_range(1, 12);
				else if (roll < 95)
					len = $urandom_range(13, 127);
				else
					len = $urandom_range(128, 260);   // two length octets
				if (len > cfg_max_len)
					len = $urandom_range(0, cfg_max_len);
				eob = ($urandom_range(0, 4) == 0);
				send_field(absent, len, eob);
			end
		end
	endtask

	// one broken sequence picked at random, or plain noise, then noise that
	// after a broken sequence must all come back as the latched error
	task automatic check_sticky_error();
		int unsigned pick;
		int unsigned noise;
		int unsigned len;
		int unsigned cut;
		drain_parser();
		write_reg(CFG_MAX_LENGTH, 32'd1024);
		pick = $urandom_range(0, 9);
		write_reg(CFG_OPTIONAL_MODE,
			(pick == 3 || pick == 7) ? 32'd1 :
			(pick == 5 || pick == 9) ? 32'($urandom_range(0, 1)) : 32'd0);
		noise = 20;
		case (pick)
			0: begin
				// fifth length octet with a bit above 31
				repeat (4) send_byte({1'b1, 7'($urandom)}, 1'b0);
				send_byte({4'($urandom_range(1, 15)), 4'($urandom)}, 1'($urandom));
			end
			1: begin
				// padded length; the zero limit would also fail but ranks lower
				write_reg(CFG_MAX_LENGTH, 32'd0);
				send_byte({1'b1, 7'($urandom)}, 1'b0);
				repeat ($urandom_range(0, 2)) send_byte(8'h80, 1'b0);
				send_byte(8'h00, 1'($urandom));
			end
			2: begin
				// one past the limit, with end of buffer that ranks lower
				len = $urandom_range(0, 200);
				write_reg(CFG_MAX_LENGTH, 32'(len));
				send_length(32'(len + 1), 1'b1);
			end
			3: send_byte(8'h01, 1'b1);   // buffer ends on a presence byte
			4: send_byte({1'b1, 7'($urandom)}, 1'b1);   // unfinished length
			5: begin
				// nonzero length on the last byte of the buffer
				if (cfg_optional)
					send_byte(8'h01, 1'b0);
				send_length($urandom_range(1, 100), 1'b1);
			end
			6: begin
				// buffer ends on a payload byte that is not the final one
				len = $urandom_range(2, 20);
				cut = $urandom_range(0, len - 2);
				send_length(32'(len), 1'b0);
				repeat (cut) send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end
			7: send_byte(8'($urandom_range(2, 255)), 1'($urandom));   // bad presence
			8: begin
				// five-octet length under the widest limit, cut short
				write_reg(CFG_MAX_LENGTH, 32'hffff_ffff);
				send_length({4'($urandom_range(1, 15)), 28'($urandom)}, 1'b0);
				repeat (3) send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end
			default: noise = 40;   // plain noise under the current mode
		endcase
		repeat (noise) send_byte(8'($urandom), 1'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls and the field-by-field check
	// ------------------------------------------------------------------------

	initial begin : result_stalls
		int unsigned run;
		int unsigned stall;
		int unsigned roll;
		forever begin
			// mostly short ready runs, now and then a long one with no stall
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
			                                  : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			roll = $urandom_range(0, 99);
			stall = (roll < 75) ? $urandom_range(1, 3) :
			        (roll < 95) ? $urandom_range(4, 10) : $urandom_range(20, 40);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// tdata: [7:0] payload_byte, [39:8] field_length, [42:40] error_code
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_results.size() == 0) begin
				$error("result transfer with no result owed by the parser");
				mismatches++;
			end else begin
				want = parsed_results.pop_front();
				if (m_tuser !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser);
					mismatches++;
				end
				if (m_tdata[7:0] !== want.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h",
						want.payload_byte, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[39:8] !== want.field_length) begin
					$error("field_length: expected %0d, got %0d",
						want.field_length, m_tdata[39:8]);
					mismatches++;
				end
				if (m_tlast !== want.last_of_field) begin
					$error("last_of_field: expected %0d, got %0d",
						want.last_of_field, m_tlast);
					mismatches++;
				end
				if (m_tdata[42:40] !== want.error_code) begin
					$error("error_code: expected %0d, got %0d",
						want.error_code, m_tdata[42:40]);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequence and end of run
	// ------------------------------------------------------------------------

	initial begin : run_tests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		check_plain_fields();
		check_optional_fields();
		check_length_limits();
		check_random_fields();
		check_sticky_error();
		drain_parser();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
design/cvfp_pkg.sv
design/cvfp_in_reg.sv
design/cvfp_parse.sv
design/cvfp_out_reg.sv
design/canonical_varuint_field_parser.sv
bench/tb_canonical_varuint_field_parser.sv
